// ===== hdl/pol_pkg.sv =====
package pol_pkg;

    // Default number of list entries.
    localparam int DEPTH_DEFAULT = 16;

    // Fixed field widths of one beat.
    localparam int REQ_W   = 2;
    localparam int POS_W   = 5;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    // Status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic             ins_ok;
        logic             del_ok;
        logic [POS_W-1:0] pos;
    } t_cell_cmd;

endpackage

// ===== hdl/pol_cell.sv =====
module pol_cell #(
    parameter int IDX = 0
) (
    input  logic                      i_clk,
    input  pol_pkg::t_cell_cmd        i_cmd,
    input  logic [pol_pkg::DATA_W-1:0] i_value,
    input  logic [pol_pkg::DATA_W-1:0] i_left,
    input  logic [pol_pkg::DATA_W-1:0] i_right,
    output logic [pol_pkg::DATA_W-1:0] o_data,
    output logic [pol_pkg::DATA_W-1:0] o_next,
    output logic [pol_pkg::DATA_W-1:0] o_tap
);
    import pol_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    int                pos_i;

    assign pos_i = int'(i_cmd.pos);

    // An insert loads at the position and shifts the tail right; a delete
    // pulls the tail left from the position on.
    always_comb begin
        n_data = r_data;
        if (i_cmd.ins_ok) begin
            if (IDX + 1 == pos_i) begin
                n_data = i_value;
            end else if (IDX + 1 > pos_i) begin
                n_data = i_left;
            end
        end else if (i_cmd.del_ok) begin
            if (IDX + 1 >= pos_i) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // The cell just before the position offers its value, which becomes the
    // new last entry when the last entry is deleted.
    assign o_tap  = (IDX + 2 == pos_i) ? r_data : '0;
    assign o_data = r_data;
    assign o_next = n_data;

endmodule

// ===== hdl/positional_ordered_list.sv =====
// Channel  | Ports                                         | Handshake
// ---------+-----------------------------------------------+----------------------------
// request  | i_req_type, i_position, i_value               | start high while busy low
// result   | o_status, o_count, o_first_value, o_last_value | o_strobe, one cycle
//
// One request is taken per clock cycle while busy is low; its result is shown
// in the cycle after the beat, set by the update of the cell chain and the result register.
// Every cell shifts, loads or holds in the same cycle, so the cost per request
// does not depend on the position or the list length.
// Reset is synchronous; busy is high for the first cycle after reset only.
// The receiver cannot stall: o_strobe marks each result for exactly one cycle.
module positional_ordered_list #(
    parameter int DEPTH = pol_pkg::DEPTH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [pol_pkg::REQ_W-1:0]   i_req_type,
    input  logic [pol_pkg::POS_W-1:0]   i_position,
    input  logic signed [pol_pkg::DATA_W-1:0] i_value,
    output logic                        o_strobe,
    output logic [pol_pkg::STAT_W-1:0]  o_status,
    output logic [pol_pkg::COUNT_W-1:0] o_count,
    output logic signed [pol_pkg::DATA_W-1:0] o_first_value,
    output logic signed [pol_pkg::DATA_W-1:0] o_last_value
);
    import pol_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic              r_ready;
    logic              r_strobe;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    t_status           r_status;
    t_status           n_status;
    logic [DATA_W-1:0] r_first;
    logic [DATA_W-1:0] n_first;
    logic [DATA_W-1:0] r_last;
    logic [DATA_W-1:0] n_last;

    logic              accept;
    int                count_i;
    int                pos_i;
    t_cell_cmd         cmd;
    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DATA_W-1:0] cell_next [DEPTH];
    logic [DATA_W-1:0] cell_tap  [DEPTH];
    logic [DATA_W-1:0] tap_or;
    logic [31:0]       count_ext;

    assign accept  = start & r_ready;
    assign busy    = ~r_ready;
    assign count_i = int'(r_count);
    assign pos_i   = int'(i_position);

    // Request decode: status, new length and the command for the cells.
    always_comb begin
        n_status   = ST_OK;
        n_count    = r_count;
        cmd.ins_ok = 1'b0;
        cmd.del_ok = 1'b0;
        cmd.pos    = i_position;
        unique case (t_req'(i_req_type))
            REQ_INSERT: begin
                if (count_i >= DEPTH) begin
                    n_status = ST_FULL;
                end else if (pos_i == 0 || pos_i > count_i + 1) begin
                    n_status = ST_BADPOS;
                end else begin
                    cmd.ins_ok = accept;
                    n_count    = r_count + CW'(1);
                end
            end
            REQ_DELETE: begin
                if (count_i == 0) begin
                    n_status = ST_EMPTY;
                end else if (pos_i == 0 || pos_i > count_i) begin
                    n_status = ST_BADPOS;
                end else begin
                    cmd.del_ok = accept;
                    n_count    = r_count - CW'(1);
                end
            end
            REQ_CLEAR: begin
                n_count = '0;
            end
            REQ_NONE: begin
                n_count = r_count;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Chain of cells, each handing its value to a neighbor on a shift.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;
        if (k == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[k-1];
        end
        if (k == DEPTH - 1) begin : g_end
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_data[k+1];
        end
        pol_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_value (i_value),
            .i_left  (left_d),
            .i_right (right_d),
            .o_data  (cell_data[k]),
            .o_next  (cell_next[k]),
            .o_tap   (cell_tap[k])
        );
    end

    // At most one cell offers a nonzero tap, so an OR picks it out.
    always_comb begin
        tap_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            tap_or = tap_or | cell_tap[k];
        end
    end

    // Track the last entry: it changes only on an insert or delete at the end, or when the list becomes empty.
    always_comb begin
        n_last = r_last;
        if (cmd.ins_ok && pos_i == count_i + 1) begin
            n_last = i_value;
        end else if (cmd.del_ok && pos_i == count_i) begin
            n_last = tap_or;
        end
        if (n_count == '0) begin
            n_last = '0;
        end
        n_first = (n_count == '0) ? '0 : cell_next[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready  <= 1'b0;
            r_strobe <= 1'b0;
            r_count  <= '0;
            r_last   <= '0;
        end else begin
            r_ready  <= 1'b1;
            r_strobe <= accept;
            if (accept) begin
                r_count <= n_count;
                r_last  <= n_last;
            end
        end
    end

    // Result register for the fields that are not kept as list state.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_first  <= n_first;
        end
    end

    assign count_ext     = 32'(r_count);
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_count       = count_ext[COUNT_W-1:0];
    assign o_first_value = r_first;
    assign o_last_value  = r_last;

endmodule
